// ----- hw/rtl/llfs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llfs_pkg: shared types and constants for the least-laxity-first scheduler
// Word field widths, input modes, result kinds and cell-chain flag groups.
// ----------------------------------------------------------------------------
package llfs_pkg;

  localparam int JobSlotsDef  = 16;
  localparam int TimeBitsDef  = 16;
  localparam int ModeBits     = 2;
  localparam int SlotBits     = 4;   // slot field of a job word
  localparam int FieldBits    = 16;  // time fields on the ports
  localparam int RemBits      = 16;  // stored remaining service

  typedef enum logic [ModeBits-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_ENDED   = 1'b1;

  // Flags travelling with the scan token along the cell chain
  typedef struct packed {
    logic scan;       // token present
    logic found;      // some eligible job seen so far
    logic best_le1;   // best job has at most one tick left
    logic work_zero;  // working job laxity is zero
    logic work_le1;   // working job has at most one tick left
  } tok_flags_t;

  // Broadcast command from the controller to all cells
  typedef struct packed {
    logic clear;
    logic load;
    logic dec;
    logic fin;
  } cell_cmd_t;

  typedef struct packed {
    logic                 kind;
    logic [SlotBits-1:0]  job_slot;
    logic [FieldBits-1:0] segment_start;
    logic [FieldBits-1:0] segment_end;
    logic                 last;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/llfs_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llfs_if: valid/ready channels of the scheduler
// Job word channel and result word channel.
// ----------------------------------------------------------------------------
interface llfs_job_if;
  logic                           valid;
  logic                           ready;
  logic [llfs_pkg::ModeBits-1:0]  mode;
  logic [llfs_pkg::SlotBits-1:0]  slot;
  logic [llfs_pkg::FieldBits-1:0] arrival_time;
  logic [llfs_pkg::FieldBits-1:0] deadline;
  logic [llfs_pkg::FieldBits-1:0] service_time;

  modport source (output valid, mode, slot, arrival_time, deadline, service_time,
                  input ready);
  modport sink   (input valid, mode, slot, arrival_time, deadline, service_time,
                  output ready);
endinterface

interface llfs_res_if;
  logic                           valid;
  logic                           ready;
  logic                           kind;
  logic [llfs_pkg::SlotBits-1:0]  job_slot;
  logic [llfs_pkg::FieldBits-1:0] segment_start;
  logic [llfs_pkg::FieldBits-1:0] segment_end;
  logic                           last;

  modport source (output valid, kind, job_slot, segment_start, segment_end, last,
                  input ready);
  modport sink   (input valid, kind, job_slot, segment_start, segment_end, last,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/least_laxity_first_scheduler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Clear and load words act when accepted; a tick word's results follow the scan
//   token as it crosses the registered stage of every cell in the row.
// No new word is accepted while a scan runs or its result words are pending.
// A tick after the schedule has ended answers with an ended word, without a scan.
// Reset (async, active low) empties the table and zeroes time, begin and flags.
// ----------------------------------------------------------------------------
// least_laxity_first_scheduler_top: least-laxity-first job scheduler
// Row of job cells scanned by a travelling token, plus a tick controller.
// ----------------------------------------------------------------------------
module least_laxity_first_scheduler_top #(
  parameter int JOB_SLOTS = llfs_pkg::JobSlotsDef,
  parameter int TIME_BITS = llfs_pkg::TimeBitsDef
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  llfs_job_if.sink  job_i,
  llfs_res_if.source res_o
);

  // Index width of the slot row and width of a signed laxity value
  localparam int SlotW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
  localparam int LaxW  = ((TIME_BITS > llfs_pkg::RemBits) ? TIME_BITS
                                                          : llfs_pkg::RemBits) + 2;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                 state_q;
  logic [TIME_BITS-1:0]   now_q, begin_q;
  logic [SlotW-1:0]       work_q;
  logic                   busy_q, ended_q;

  // Result buffer: a tick makes at most two words, both written at once
  llfs_pkg::res_t         res_q [2];
  logic [1:0]             res_n_q;
  logic                   res_rd_q;

  // Chain of cells; index 0 is the token source, JOB_SLOTS the end of the row
  llfs_pkg::tok_flags_t   tok_f [JOB_SLOTS+1];
  logic [SlotW-1:0]       tok_idx [JOB_SLOTS+1];
  logic [LaxW-1:0]        tok_lax [JOB_SLOTS+1];

  llfs_pkg::cell_cmd_t    cmd;
  logic [SlotW-1:0]       cmd_slot;

  logic                   accept, in_range, is_tick_start, done;
  llfs_pkg::mode_e        mode;

  // decision signals at the end of a scan
  llfs_pkg::tok_flags_t   fin_f;
  logic [SlotW-1:0]       best_idx, w0, w_fin;
  logic                   lz0, le0, le_fin;
  logic [TIME_BITS-1:0]   beg0, beg_fin, now_nxt;
  llfs_pkg::res_t         seg_swap, seg_fin, res_ended;

  assign mode     = llfs_pkg::mode_e'(job_i.mode);
  assign job_i.ready = (state_q == ST_IDLE) && (res_n_q == 2'd0);
  assign accept   = job_i.valid && job_i.ready;
  // the slot field reaches slots 0 to 15, so only a row shorter than that can miss
  assign in_range = (32'(job_i.slot) < 32'(JOB_SLOTS));
  assign is_tick_start = accept && (mode == llfs_pkg::MODE_TICK) && !ended_q;

  assign fin_f    = tok_f[JOB_SLOTS];
  assign best_idx = tok_idx[JOB_SLOTS];
  assign done     = (state_q == ST_SCAN) && fin_f.scan;

  // Working job before any laxity swap: an idle processor takes the pick
  assign w0   = busy_q ? work_q : best_idx;
  assign lz0  = busy_q ? fin_f.work_zero : (tok_lax[JOB_SLOTS] == '0);
  assign le0  = busy_q ? fin_f.work_le1 : fin_f.best_le1;
  assign beg0 = busy_q ? begin_q : now_q;

  // Zero laxity closes the running segment and hands over to the pick
  assign w_fin   = lz0 ? best_idx : w0;
  assign le_fin  = lz0 ? fin_f.best_le1 : le0;
  assign beg_fin = lz0 ? now_q : beg0;
  assign now_nxt = (now_q == '1) ? now_q : (now_q + TIME_BITS'(1));

  always_comb begin
    seg_swap.kind          = llfs_pkg::KIND_SEGMENT;
    seg_swap.job_slot      = llfs_pkg::SlotBits'(w0);
    seg_swap.segment_start = llfs_pkg::FieldBits'(beg0);
    seg_swap.segment_end   = llfs_pkg::FieldBits'(now_q);
    seg_swap.last          = !le_fin;

    seg_fin.kind           = llfs_pkg::KIND_SEGMENT;
    seg_fin.job_slot       = llfs_pkg::SlotBits'(w_fin);
    seg_fin.segment_start  = llfs_pkg::FieldBits'(beg_fin);
    seg_fin.segment_end    = llfs_pkg::FieldBits'(now_nxt);
    seg_fin.last           = 1'b1;

    res_ended              = '0;
    res_ended.kind         = llfs_pkg::KIND_ENDED;
    res_ended.last         = 1'b1;
  end

  // Broadcast to the cells: clear, load and the one-tick run of the working job
  always_comb begin
    cmd       = '0;
    cmd_slot  = SlotW'(job_i.slot);
    if (accept && (mode == llfs_pkg::MODE_CLEAR)) begin
      cmd.clear = 1'b1;
    end
    if (accept && (mode == llfs_pkg::MODE_LOAD) && in_range) begin
      cmd.load = 1'b1;
    end
    if (done && fin_f.found) begin
      cmd.dec  = 1'b1;
      cmd.fin  = le_fin;
      cmd_slot = w_fin;
    end
  end

  // Token source feeds the first cell only on a tick start
  always_comb begin
    tok_f[0]      = '0;
    tok_f[0].scan = is_tick_start;
    tok_idx[0]    = '0;
    tok_lax[0]    = '0;
  end

  for (genvar g = 0; g < JOB_SLOTS; g++) begin : g_cell
    llfs_cell #(
      .IDX       (g),
      .SLOT_W    (SlotW),
      .TIME_BITS (TIME_BITS),
      .LAX_W     (LaxW)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .cmd_slot_i     (cmd_slot),
      .ld_arrival_i   (TIME_BITS'(job_i.arrival_time)),
      .ld_deadline_i  (TIME_BITS'(job_i.deadline)),
      .ld_remaining_i (llfs_pkg::RemBits'(job_i.service_time)),
      .now_i          (now_q),
      .work_slot_i    (work_q),
      .tok_i          (tok_f[g]),
      .tok_idx_i      (tok_idx[g]),
      .tok_lax_i      (tok_lax[g]),
      .tok_o          (tok_f[g+1]),
      .tok_idx_o      (tok_idx[g+1]),
      .tok_lax_o      (tok_lax[g+1])
    );
  end

  // Controller: state, time, working job and the result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      now_q    <= '0;
      begin_q  <= '0;
      work_q   <= '0;
      busy_q   <= 1'b0;
      ended_q  <= 1'b0;
      res_n_q  <= 2'd0;
      res_rd_q <= 1'b0;
    end else begin
      // word taken at the output
      if (res_o.valid && res_o.ready) begin
        if (res_n_q == 2'd1) begin
          res_n_q  <= 2'd0;
          res_rd_q <= 1'b0;
        end else begin
          res_n_q  <= res_n_q - 2'd1;
          res_rd_q <= ~res_rd_q;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (mode)
              llfs_pkg::MODE_CLEAR: begin
                now_q   <= '0;
                begin_q <= '0;
                work_q  <= '0;
                busy_q  <= 1'b0;
                ended_q <= 1'b0;
              end
              llfs_pkg::MODE_TICK: begin
                if (ended_q) begin
                  res_q[0] <= res_ended;
                  res_n_q  <= 2'd1;
                  res_rd_q <= 1'b0;
                end else begin
                  state_q  <= ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (done) begin
            state_q  <= ST_IDLE;
            res_rd_q <= 1'b0;
            if (!fin_f.found) begin
              ended_q  <= 1'b1;
              res_q[0] <= res_ended;
              res_n_q  <= 2'd1;
            end else begin
              now_q  <= now_nxt;
              work_q <= w_fin;
              busy_q <= !le_fin;
              begin_q <= le_fin ? now_nxt : beg_fin;
              if (lz0) begin
                res_q[0] <= seg_swap;
                res_q[1] <= seg_fin;
                res_n_q  <= le_fin ? 2'd2 : 2'd1;
              end else begin
                res_q[0] <= seg_fin;
                res_n_q  <= le_fin ? 2'd1 : 2'd0;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign res_o.valid         = (res_n_q != 2'd0);
  assign res_o.kind          = res_q[res_rd_q].kind;
  assign res_o.job_slot      = res_q[res_rd_q].job_slot;
  assign res_o.segment_start = res_q[res_rd_q].segment_start;
  assign res_o.segment_end   = res_q[res_rd_q].segment_end;
  assign res_o.last          = res_q[res_rd_q].last;

endmodule
`default_nettype wire

// ----- hw/rtl/llfs_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llfs_cell: one job slot of the scheduler chain
// Holds one job and folds it into the least-laxity token passing through.
// ----------------------------------------------------------------------------
module llfs_cell #(
  parameter int IDX       = 0,
  parameter int SLOT_W    = 4,
  parameter int TIME_BITS = llfs_pkg::TimeBitsDef,
  parameter int LAX_W     = 18
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  llfs_pkg::cell_cmd_t            cmd_i,
  input  wire [SLOT_W-1:0]               cmd_slot_i,
  input  wire [TIME_BITS-1:0]            ld_arrival_i,
  input  wire [TIME_BITS-1:0]            ld_deadline_i,
  input  wire [llfs_pkg::RemBits-1:0]    ld_remaining_i,
  input  wire [TIME_BITS-1:0]            now_i,
  input  wire [SLOT_W-1:0]               work_slot_i,
  input  llfs_pkg::tok_flags_t           tok_i,
  input  wire [SLOT_W-1:0]               tok_idx_i,
  input  wire [LAX_W-1:0]                tok_lax_i,
  output llfs_pkg::tok_flags_t           tok_o,
  output logic [SLOT_W-1:0]              tok_idx_o,
  output logic [LAX_W-1:0]               tok_lax_o
);

  localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(IDX);

  logic                         valid_q, fin_q;
  logic [TIME_BITS-1:0]         arrival_q, deadline_q;
  logic [llfs_pkg::RemBits-1:0] rem_q;

  logic                 sel, eligible, take, is_work, rem_le1;
  logic [LAX_W-1:0]     lax;
  llfs_pkg::tok_flags_t tok_d;

  assign sel      = (cmd_slot_i == MyIdx);
  assign eligible = valid_q && !fin_q && (arrival_q <= now_i);
  assign lax      = LAX_W'(deadline_q) - LAX_W'(rem_q) - LAX_W'(now_i);
  assign take     = eligible && (!tok_i.found || ($signed(lax) < $signed(tok_lax_i)));
  assign is_work  = (work_slot_i == MyIdx);
  assign rem_le1  = (rem_q <= llfs_pkg::RemBits'(1));

  always_comb begin
    tok_d           = tok_i;
    tok_d.found     = tok_i.found || eligible;
    tok_d.best_le1  = take ? rem_le1 : tok_i.best_le1;
    tok_d.work_zero = is_work ? (lax == '0) : tok_i.work_zero;
    tok_d.work_le1  = is_work ? rem_le1 : tok_i.work_le1;
  end

  // slot state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fin_q   <= 1'b0;
    end else if (cmd_i.clear) begin
      valid_q <= 1'b0;
      fin_q   <= 1'b0;
    end else if (cmd_i.load && sel) begin
      valid_q <= 1'b1;
      fin_q   <= 1'b0;
    end else if (cmd_i.dec && sel && cmd_i.fin) begin
      fin_q   <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && sel) begin
      arrival_q  <= ld_arrival_i;
      deadline_q <= ld_deadline_i;
      rem_q      <= ld_remaining_i;
    end else if (cmd_i.dec && sel && (rem_q != '0)) begin
      rem_q      <= rem_q - llfs_pkg::RemBits'(1);
    end
  end

  // token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_o <= '0;
    end else begin
      tok_o <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_idx_o <= take ? MyIdx : tok_idx_i;
    tok_lax_o <= take ? lax : tok_lax_i;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/llfs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llfs_checker: port-level checks for the scheduler
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module llfs_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire        kind_i,
  input wire [3:0]  job_slot_i,
  input wire [15:0] segment_start_i,
  input wire [15:0] segment_end_i,
  input wire        last_i
);

  // an ended word carries no segment and closes its item
  a_ended_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (kind_i == llfs_pkg::KIND_ENDED)) |->
      (job_slot_i == 4'd0 && segment_start_i == 16'd0 &&
       segment_end_i == 16'd0 && last_i))
    else $error("ended word with segment fields or without last");

  // no new job word while results of the previous one are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while results pending");

  // the second word of a pair follows straight after the first
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_i) |=> out_valid_i)
    else $error("first word of a pair not followed");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(kind_i) && $stable(job_slot_i) &&
       $stable(segment_start_i) && $stable(segment_end_i) && $stable(last_i)))
    else $error("stalled result word changed");

endmodule

bind least_laxity_first_scheduler_top llfs_checker u_llfs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (job_i.valid),
  .in_ready_i      (job_i.ready),
  .out_valid_i     (res_o.valid),
  .out_ready_i     (res_o.ready),
  .kind_i          (res_o.kind),
  .job_slot_i      (res_o.job_slot),
  .segment_start_i (res_o.segment_start),
  .segment_end_i   (res_o.segment_end),
  .last_i          (res_o.last)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench for least_laxity_first_scheduler_top
// Directed and random clear/load/tick words are offered on the job channel.
// A behavioural schedule model predicts every result word, and the result
// channel is checked in order, field by field, under random back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import llfs_pkg::*;

  localparam int Slots       = JobSlotsDef;
  localparam int TickCycles  = Slots + 4;      // token scan plus handshake slack
  localparam int CycleLimit  = 1_000_000;
  localparam int RandomWords = 1000;
  localparam int HoldCycles  = 600;            // long result stall, fills the block

  localparam logic [ModeBits-1:0]  ModeSpare = 2'd3;  // unused code, block ignores it
  localparam logic [FieldBits-1:0] TimeTop   = '1;

  typedef struct packed {
    logic [ModeBits-1:0]  mode;
    logic [SlotBits-1:0]  slot;
    logic [FieldBits-1:0] arrival;
    logic [FieldBits-1:0] deadline;
    logic [FieldBits-1:0] service;
  } job_word_t;

  logic clk_i;
  logic rst_ni;

  llfs_job_if job_if ();
  llfs_res_if res_if ();

  least_laxity_first_scheduler_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .job_i  (job_if),
    .res_o  (res_if)
  );

  // --------------------------------------------------------------------------
  // Schedule model state. Mirrors the block's table and tick controller.
  // Times, deadlines and remaining counts are held at port width.
  // --------------------------------------------------------------------------
  logic                 slot_used [Slots] = '{default: 1'b0};
  logic                 slot_done [Slots] = '{default: 1'b0};
  logic [FieldBits-1:0] slot_arr  [Slots] = '{default: '0};
  logic [FieldBits-1:0] slot_dl   [Slots] = '{default: '0};
  logic [RemBits-1:0]   slot_rem  [Slots] = '{default: '0};
  logic [FieldBits-1:0] now_tick   = '0;
  logic [FieldBits-1:0] seg_begin  = '0;
  logic [SlotBits-1:0]  run_slot   = '0;
  logic                 running    = 1'b0;
  logic                 sched_over = 1'b0;

  res_t      expected_records [$];  // result words still owed by the block
  job_word_t pending_words    [$];  // stimulus not yet offered

  job_word_t   offered_word;
  int unsigned src_gap, src_quiet, snk_gap, snk_quiet;
  int unsigned words_sent, ticks_sent, results_seen, mismatch_count, cycle_count;
  logic        hold_sink;

  // Laxity may go negative once a job is late, so work in signed int.
  function automatic int laxity_of_slot(int s);
    return int'(slot_dl[s]) - int'(slot_rem[s]) - int'(now_tick);
  endfunction

  function automatic res_t segment_record(logic [SlotBits-1:0] s,
                                          logic [FieldBits-1:0] b,
                                          logic [FieldBits-1:0] e);
    res_t r;
    r.kind          = KIND_SEGMENT;
    r.job_slot      = s;
    r.segment_start = b;
    r.segment_end   = e;
    r.last          = 1'b0;
    return r;
  endfunction

  // Apply one accepted job word to the model and queue the results it owes.
  task automatic advance_schedule(input job_word_t w);
    res_t out [2];
    int   n;
    int   pick;
    int   best;
    n    = 0;
    pick = -1;
    best = 0;
    case (w.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < Slots; i++) begin
          slot_used[i] = 1'b0;
          slot_done[i] = 1'b0;
        end
        now_tick   = '0;
        seg_begin  = '0;
        run_slot   = '0;
        running    = 1'b0;
        sched_over = 1'b0;
      end
      MODE_LOAD: begin
        slot_used[w.slot] = 1'b1;
        slot_done[w.slot] = 1'b0;
        slot_arr[w.slot]  = w.arrival;
        slot_dl[w.slot]   = w.deadline;
        slot_rem[w.slot]  = w.service;
      end
      MODE_TICK: begin
        // least laxity among arrived, unfinished jobs; strict < keeps lowest slot
        if (!sched_over) begin
          for (int i = 0; i < Slots; i++) begin
            if (slot_used[i] && !slot_done[i] && slot_arr[i] <= now_tick) begin
              if (pick < 0 || laxity_of_slot(i) < best) begin
                pick = i;
                best = laxity_of_slot(i);
              end
            end
          end
        end
        if (pick < 0) begin
          sched_over           = 1'b1;
          out[0].kind          = KIND_ENDED;
          out[0].job_slot      = '0;
          out[0].segment_start = '0;
          out[0].segment_end   = '0;
          out[0].last          = 1'b0;
          n = 1;
        end else begin
          if (!running) begin
            run_slot  = SlotBits'(pick);
            seg_begin = now_tick;
          end
          // working job out of slack: close its segment (may be empty), hand over
          if (laxity_of_slot(int'(run_slot)) == 0) begin
            out[n] = segment_record(run_slot, seg_begin, now_tick);
            n++;
            run_slot  = SlotBits'(pick);
            seg_begin = now_tick;
          end
          running = 1'b1;
          if (slot_rem[run_slot] != 0) slot_rem[run_slot]--;
          if (now_tick != TimeTop) now_tick++;
          if (slot_rem[run_slot] == 0) begin
            out[n] = segment_record(run_slot, seg_begin, now_tick);
            n++;
            seg_begin           = now_tick;
            slot_done[run_slot] = 1'b1;
            running             = 1'b0;
          end
        end
      end
      default: ;
    endcase
    for (int k = 0; k < n; k++) begin
      out[k].last = (k == n - 1);
      expected_records.push_back(out[k]);
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH result %0d: %s", $time, results_seen, what);
  endtask

  // Idle length: mostly none or short, now and then long, with quiet stretches.
  function automatic int unsigned draw_gap(inout int unsigned quiet);
    int unsigned r;
    if (quiet != 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_word(input logic [ModeBits-1:0] mode, input logic [SlotBits-1:0] slot,
                            input logic [FieldBits-1:0] arr, input logic [FieldBits-1:0] dl,
                            input logic [FieldBits-1:0] svc);
    job_word_t w;
    w.mode     = mode;
    w.slot     = slot;
    w.arrival  = arr;
    w.deadline = dl;
    w.service  = svc;
    pending_words.push_back(w);
  endtask

  // Padding fields of clear/tick/spare words: random, so every bit toggles.
  task automatic queue_control(input logic [ModeBits-1:0] mode);
    queue_word(mode, SlotBits'($urandom), FieldBits'($urandom), FieldBits'($urandom),
               FieldBits'($urandom));
  endtask

  // Mostly small, near-critical jobs so that slack runs out and jobs finish
  // inside a scenario; a few late jobs and a few full-width ones.
  task automatic queue_random_job();
    logic [FieldBits-1:0] arr, dl, svc;
    arr = FieldBits'($urandom_range(0, 12));
    svc = ($urandom_range(0, 19) == 0) ? '0 : FieldBits'($urandom_range(1, 6));
    if ($urandom_range(0, 9) == 0) dl = arr + svc - FieldBits'($urandom_range(1, 3));
    else                           dl = arr + svc + FieldBits'($urandom_range(0, 10));
    if ($urandom_range(0, 15) == 0) begin
      arr = FieldBits'($urandom);
      dl  = FieldBits'($urandom);
      svc = FieldBits'($urandom);
    end
    queue_word(MODE_LOAD, SlotBits'($urandom), arr, dl, svc);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Job word driver. The model is updated at the edge where a word is taken;
  // valid is assigned once per edge so back-to-back words stay high.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : p_drive
    logic offering;
    if (!rst_ni) begin
      job_if.valid <= 1'b0;
    end else begin
      offering = job_if.valid;
      if (job_if.valid && job_if.ready) begin
        advance_schedule(offered_word);
        words_sent++;
        if (offered_word.mode == MODE_TICK) ticks_sent++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (src_gap != 0) begin
          src_gap--;
          job_if.valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          offered_word = pending_words.pop_front();
          job_if.valid        <= 1'b1;
          job_if.mode         <= offered_word.mode;
          job_if.slot         <= offered_word.slot;
          job_if.arrival_time <= offered_word.arrival;
          job_if.deadline     <= offered_word.deadline;
          job_if.service_time <= offered_word.service;
          src_gap = draw_gap(src_quiet);
        end else begin
          job_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result word monitor: in-order, field-by-field compare, random ready.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : p_collect
    res_t got, want;
    logic take;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got.kind          = res_if.kind;
        got.job_slot      = res_if.job_slot;
        got.segment_start = res_if.segment_start;
        got.segment_end   = res_if.segment_end;
        got.last          = res_if.last;
        results_seen++;
        if (expected_records.size() == 0) begin
          report_mismatch($sformatf("unexpected word kind %0d slot %0d %0d..%0d last %0d",
                                    got.kind, got.job_slot, got.segment_start,
                                    got.segment_end, got.last));
        end else begin
          want = expected_records.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
          if (got.job_slot !== want.job_slot)
            report_mismatch($sformatf("job_slot got %0d want %0d", got.job_slot,
                                      want.job_slot));
          if (got.segment_start !== want.segment_start)
            report_mismatch($sformatf("segment_start got %0d want %0d", got.segment_start,
                                      want.segment_start));
          if (got.segment_end !== want.segment_end)
            report_mismatch($sformatf("segment_end got %0d want %0d", got.segment_end,
                                      want.segment_end));
          if (got.last !== want.last)
            report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
        end
        snk_gap = draw_gap(snk_quiet);
      end
      if (hold_sink) begin
        take = 1'b0;
      end else if (snk_gap != 0) begin
        snk_gap--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      res_if.ready <= take;
    end
  end

  // Long result stall once traffic is flowing; the driver keeps offering,
  // so the block's output side backs up into job_if.ready.
  initial begin : p_hold
    hold_sink = 1'b0;
    wait (results_seen >= 40);
    @(posedge clk_i);
    hold_sink <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_sink <= 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin : p_watchdog
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results owed", CycleLimit,
               expected_records.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : p_main
    int unsigned planned;
    int unsigned jobs;
    int unsigned ticks;
    int unsigned r;

    // known levels on every block input from time zero
    job_if.valid        = 1'b0;
    job_if.mode         = MODE_CLEAR;
    job_if.slot         = '0;
    job_if.arrival_time = '0;
    job_if.deadline     = '0;
    job_if.service_time = '0;
    res_if.ready        = 1'b0;
    rst_ni              = 1'b0;
    planned             = 0;

    // -- directed part --------------------------------------------------------
    // slot 1 has no slack at tick 0: first tick closes an empty segment and
    // restarts it; slot 3 has zero service and is already late; slot 15
    // never arrives, so the schedule ends and further ticks report the end.
    queue_word(MODE_CLEAR, '0, '0, '0, '0);
    queue_word(MODE_LOAD, 4'd1, 16'd0, 16'd2, 16'd2);
    queue_word(MODE_LOAD, 4'd2, 16'd1, 16'd5, 16'd1);
    queue_word(MODE_LOAD, 4'd3, 16'd0, 16'd0, 16'd0);
    queue_word(MODE_LOAD, 4'd15, TimeTop, TimeTop, TimeTop);
    queue_word(ModeSpare, 4'hF, TimeTop, TimeTop, TimeTop);
    repeat (6) queue_word(MODE_TICK, '0, '0, '0, '0);
    // a load after the end must not revive the schedule
    queue_word(MODE_LOAD, 4'd4, 16'd0, 16'd9, 16'd1);
    queue_word(MODE_TICK, '0, '0, '0, '0);
    // overwrite before start, then load while a job is running
    queue_word(MODE_CLEAR, 4'hF, TimeTop, TimeTop, TimeTop);
    queue_word(MODE_LOAD, 4'd0, 16'd0, TimeTop, 16'd3);
    queue_word(MODE_LOAD, 4'd0, 16'd0, 16'd4, 16'd4);
    queue_word(MODE_TICK, '0, '0, '0, '0);
    queue_word(MODE_LOAD, 4'd5, 16'd0, 16'd1, 16'd1);
    repeat (4) queue_word(MODE_TICK, TimeTop[SlotBits-1:0], TimeTop, TimeTop, TimeTop);

    // -- random scenarios: clear, fill a few slots, tick through ----------------
    // Noise within the ticks: late loads, spare-mode words, stray clears.
    while (planned < RandomWords) begin
      if ($urandom_range(0, 9) != 0) begin
        queue_control(MODE_CLEAR);
        planned++;
      end
      jobs = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
      repeat (jobs) begin
        queue_random_job();
        planned++;
      end
      ticks = $urandom_range(4, 40);
      repeat (ticks) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          queue_random_job();
          planned++;
        end else if (r < 9) begin
          queue_control(ModeSpare);
        end else if (r < 10) begin
          queue_control(MODE_CLEAR);
          planned++;
        end
        queue_control(MODE_TICK);
        planned++;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: every word taken and every owed result seen
    while (pending_words.size() != 0 || job_if.valid || expected_records.size() != 0)
      @(posedge clk_i);
    // catch stray words arriving after the last expected one
    repeat (4 * TickCycles) @(posedge clk_i);
    if (expected_records.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_records.size()));

    $display("Covered %0d job words (%0d ticks) and %0d result words,", words_sent,
             ticks_sent, results_seen);
    $display("with random idling on both channels and a %0d-cycle result stall.",
             HoldCycles);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
